/* hdl/mqttp_pkg.sv */
// shared types and codes for the mqtt fixed header parser
// no dependencies

package mqttp_pkg;

	localparam int LEN_W = 28;
	localparam int ID_W  = 16;

	typedef enum logic [3:0] {
		PH_WAIT    = 4'd0,
		PH_LEN     = 4'd1,
		PH_ID_HI   = 4'd2,
		PH_ID_LO   = 4'd3,
		PH_TLEN_HI = 4'd4,
		PH_TLEN_LO = 4'd5,
		PH_TOPIC   = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_ACKF    = 4'd8,
		PH_RETC    = 4'd9,
		PH_SKIP    = 4'd10
	} phase_t;

	localparam logic [3:0] T_RSVD_LO  = 4'd0;
	localparam logic [3:0] T_CONNACK  = 4'd2;
	localparam logic [3:0] T_PUBLISH  = 4'd3;
	localparam logic [3:0] T_PUBACK   = 4'd4;
	localparam logic [3:0] T_PUBREC   = 4'd5;
	localparam logic [3:0] T_PUBREL   = 4'd6;
	localparam logic [3:0] T_PUBCOMP  = 4'd7;
	localparam logic [3:0] T_SUBSCR   = 4'd8;
	localparam logic [3:0] T_SUBACK   = 4'd9;
	localparam logic [3:0] T_UNSUB    = 4'd10;
	localparam logic [3:0] T_UNSUBACK = 4'd11;
	localparam logic [3:0] T_RSVD_HI  = 4'd15;

	localparam logic [3:0] ROLE_HDR   = 4'd0;
	localparam logic [3:0] ROLE_LEN   = 4'd1;
	localparam logic [3:0] ROLE_ID    = 4'd2;
	localparam logic [3:0] ROLE_TLEN  = 4'd3;
	localparam logic [3:0] ROLE_TOPIC = 4'd4;
	localparam logic [3:0] ROLE_PAYLD = 4'd5;
	localparam logic [3:0] ROLE_ACKF  = 4'd6;
	localparam logic [3:0] ROLE_RETC  = 4'd7;
	localparam logic [3:0] ROLE_SKIP  = 4'd8;

	localparam logic [2:0] ERR_NONE  = 3'd0;
	localparam logic [2:0] ERR_FLAGS = 3'd1;
	localparam logic [2:0] ERR_TYPE  = 3'd2;
	localparam logic [2:0] ERR_LEN   = 3'd3;
	localparam logic [2:0] ERR_LONG  = 3'd4;

	localparam logic [3:0] FLAGS_REQ = 4'd2;

	typedef struct packed {
		phase_t            phase;
		logic [3:0]        ctype;
		logic [3:0]        cflags;
		logic [LEN_W-1:0]  rem;
		logic [2:0]        lidx;
		logic [ID_W-1:0]   tlen;
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  pcount;
		logic [7:0]        ackf;
		logic [7:0]        retc;
	} st_t;

	typedef struct packed {
		logic [3:0]        packet_type;
		logic [3:0]        byte_role;
		logic [7:0]        data_byte;
		logic              packet_end;
		logic [2:0]        error_code;
		logic [ID_W-1:0]   packet_id;
		logic              dup_flag;
		logic [1:0]        qos_level;
		logic              retain_flag;
		logic [7:0]        ack_flags;
		logic [7:0]        return_code;
		logic [LEN_W-1:0]  payload_length;
	} res_t;

endpackage

/* hdl/mqtt_packet_header_parser_core.sv */
// top level of the mqtt control packet parser: input register, parse state, result register
// depends on mqttp_pkg and mqttp_step
//
// usage
// - input channel: one stream byte per transfer on rx_byte, in_valid / in_ready
// - output channel: one result per input byte, out_valid / out_ready, fields as ports
// - each byte is tagged with its role in the packet; errors and packet ends are
//   flagged on the byte that causes them, after which the next byte is a header
// - a byte taken is held in the input register, and its result is registered in
//   the result register once that register is empty or out_ready is high
// - throughput: one byte per cycle while out_ready is high; the parse state,
//   the length adder and the topic length compare all settle within the single
//   stage between the input register and the result register
// - stalls: while out_ready is low the result holds and one more byte may wait in
//   the input register; in_ready drops only when both are occupied
// - reset: arst_n clears the parse state to waiting for a fixed header and empties
//   both registers; no result is presented until a byte is taken

module mqtt_packet_header_parser_core
	import mqttp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [3:0]       packet_type,
	output logic [3:0]       byte_role,
	output logic [7:0]       data_byte,
	output logic             packet_end,
	output logic [2:0]       error_code,
	output logic [ID_W-1:0]  packet_id,
	output logic             dup_flag,
	output logic [1:0]       qos_level,
	output logic             retain_flag,
	output logic [7:0]       ack_flags,
	output logic [7:0]       return_code,
	output logic [LEN_W-1:0] payload_length
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	res_t       res_s2;
	st_t        st_q;
	st_t        st_nx;
	res_t       res_nx;
	logic       adv;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	mqttp_step u_step (
		.st      (st_q),
		.rx_byte (byte_s1),
		.nx      (st_nx),
		.res     (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_WAIT, default: '0};
		end else if (adv) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nx;
		end
	end

	assign out_valid      = valid_s2;
	assign packet_type    = res_s2.packet_type;
	assign byte_role      = res_s2.byte_role;
	assign data_byte      = res_s2.data_byte;
	assign packet_end     = res_s2.packet_end;
	assign error_code     = res_s2.error_code;
	assign packet_id      = res_s2.packet_id;
	assign dup_flag       = res_s2.dup_flag;
	assign qos_level      = res_s2.qos_level;
	assign retain_flag    = res_s2.retain_flag;
	assign ack_flags      = res_s2.ack_flags;
	assign return_code    = res_s2.return_code;
	assign payload_length = res_s2.payload_length;

`ifndef SYNTHESIS
	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> packet_end)
		else $error("error result without packet end");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled with room downstream");

	a_end_waits: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_nx.packet_end |=> st_q.phase == PH_WAIT)
		else $error("parser not back to header after packet end");

	a_hdr_ok: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_nx.byte_role == ROLE_HDR && res_nx.error_code == ERR_NONE
		|=> st_q.phase == PH_LEN)
		else $error("accepted header did not start length decode");
`endif

endmodule

/* hdl/mqttp_step.sv */
// next-state and result logic for one stream byte
// depends on mqttp_pkg

module mqttp_step
	import mqttp_pkg::*;
(
	input  st_t        st,
	input  logic [7:0] rx_byte,
	output st_t        nx,
	output res_t       res
);

	logic [LEN_W-1:0] grp;
	logic [LEN_W-1:0] len_sum;
	logic [LEN_W-1:0] rem_m1;
	logic [1:0]       idb;
	logic             len_bad;
	phase_t           first_ph;
	logic             flag_bad;
	logic [2:0]       hdr_err;
	logic [ID_W-1:0]  tl;
	logic [LEN_W:0]   tl_need;
	logic [3:0]       role;
	logic [2:0]       err;
	logic             end_p;
	logic             flags_ok;
	logic             body;
	phase_t           nxt_ph;
	logic             pub;

	assign idb    = (st.cflags[2:1] != 2'd0) ? 2'd2 : 2'd0;
	assign rem_m1 = st.rem - LEN_W'(1);
	assign tl     = {st.tlen[ID_W-1:8], rx_byte};
	assign tl_need = (LEN_W+1)'(tl) + (LEN_W+1)'(idb);

	always_comb begin
		case (st.lidx[1:0])
			2'd0:    grp = {21'd0, rx_byte[6:0]};
			2'd1:    grp = {14'd0, rx_byte[6:0], 7'd0};
			2'd2:    grp = {7'd0, rx_byte[6:0], 14'd0};
			default: grp = {rx_byte[6:0], 21'd0};
		endcase
	end

	assign len_sum = st.rem + grp;

	always_comb begin
		case (st.ctype) inside
			T_CONNACK, T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_UNSUBACK:
				len_bad = (len_sum != LEN_W'(2));
			T_SUBACK:
				len_bad = (len_sum != LEN_W'(3));
			T_PUBLISH:
				len_bad = ((LEN_W+1)'(len_sum) < (LEN_W+1)'(2) + (LEN_W+1)'(idb));
			default:
				len_bad = 1'b0;
		endcase
	end

	always_comb begin
		case (st.ctype) inside
			T_CONNACK: first_ph = PH_ACKF;
			T_PUBLISH: first_ph = PH_TLEN_HI;
			T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBACK, T_UNSUBACK:
				first_ph = PH_ID_HI;
			default:   first_ph = PH_SKIP;
		endcase
	end

	always_comb begin
		case (rx_byte[7:4]) inside
			T_PUBLISH:                  flag_bad = (rx_byte[2:1] == 2'd3);
			T_PUBREL, T_SUBSCR, T_UNSUB: flag_bad = (rx_byte[3:0] != FLAGS_REQ);
			default:                    flag_bad = (rx_byte[3:0] != 4'd0);
		endcase
		if (flag_bad) begin
			hdr_err = ERR_FLAGS;
		end else if (rx_byte[7:4] == T_RSVD_LO || rx_byte[7:4] == T_RSVD_HI) begin
			hdr_err = ERR_TYPE;
		end else begin
			hdr_err = ERR_NONE;
		end
	end

	always_comb begin
		nx       = st;
		role     = ROLE_HDR;
		err      = ERR_NONE;
		end_p    = 1'b0;
		flags_ok = 1'b1;
		body     = 1'b0;
		nxt_ph   = st.phase;
		unique case (st.phase)
			PH_LEN: begin
				role   = ROLE_LEN;
				nx.rem = len_sum;
				if (rx_byte[7]) begin
					if (st.lidx >= 3'd3) begin
						err   = ERR_LONG;
						end_p = 1'b1;
					end else begin
						nx.lidx = st.lidx + 3'd1;
					end
				end else if (len_bad) begin
					err   = ERR_LEN;
					end_p = 1'b1;
				end else if (len_sum == '0) begin
					end_p = 1'b1;
				end else begin
					nx.phase = first_ph;
				end
			end
			PH_ID_HI: begin
				body   = 1'b1;
				role   = ROLE_ID;
				nx.id  = {rx_byte, 8'd0};
				nxt_ph = PH_ID_LO;
			end
			PH_ID_LO: begin
				body   = 1'b1;
				role   = ROLE_ID;
				nx.id  = {st.id[ID_W-1:8], rx_byte};
				nxt_ph = (st.ctype == T_SUBACK) ? PH_RETC : PH_PAYLOAD;
			end
			PH_TLEN_HI: begin
				body    = 1'b1;
				role    = ROLE_TLEN;
				nx.tlen = {rx_byte, 8'd0};
				nxt_ph  = PH_TLEN_LO;
			end
			PH_TLEN_LO: begin
				body    = 1'b1;
				role    = ROLE_TLEN;
				nx.tlen = tl;
				if (tl_need > {1'b0, rem_m1}) begin
					err = ERR_LEN;
				end else begin
					nx.pcount = rem_m1 - LEN_W'(tl) - LEN_W'(idb);
					if (tl != '0) begin
						nxt_ph = PH_TOPIC;
					end else begin
						nxt_ph = (idb != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
					end
				end
			end
			PH_TOPIC: begin
				body = 1'b1;
				role = ROLE_TOPIC;
				if ({1'b0, rem_m1} == {1'b0, st.pcount} + (LEN_W+1)'(idb)) begin
					nxt_ph = (idb != 2'd0) ? PH_ID_HI : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				body = 1'b1;
				role = ROLE_PAYLD;
			end
			PH_ACKF: begin
				body    = 1'b1;
				role    = ROLE_ACKF;
				nx.ackf = rx_byte;
				nxt_ph  = PH_RETC;
			end
			PH_RETC: begin
				body    = 1'b1;
				role    = ROLE_RETC;
				nx.retc = rx_byte;
			end
			PH_SKIP: begin
				body = 1'b1;
				role = ROLE_SKIP;
			end
			default: begin
				role      = ROLE_HDR;
				nx.ctype  = rx_byte[7:4];
				nx.cflags = rx_byte[3:0];
				nx.rem    = '0;
				nx.lidx   = '0;
				nx.tlen   = '0;
				nx.id     = '0;
				nx.pcount = '0;
				nx.ackf   = '0;
				nx.retc   = '0;
				err       = hdr_err;
				if (hdr_err != ERR_NONE) begin
					end_p    = 1'b1;
					flags_ok = 1'b0;
				end else begin
					nx.phase = PH_LEN;
				end
			end
		endcase
		if (body) begin
			nx.rem = rem_m1;
			if (err != ERR_NONE || rem_m1 == '0) begin
				end_p = 1'b1;
			end else begin
				nx.phase = nxt_ph;
			end
		end
		if (end_p) begin
			nx.phase = PH_WAIT;
		end
	end

	assign pub = flags_ok && (nx.ctype == T_PUBLISH);

	always_comb begin
		res.packet_type    = nx.ctype;
		res.byte_role      = role;
		res.data_byte      = rx_byte;
		res.packet_end     = end_p;
		res.error_code     = err;
		res.packet_id      = nx.id;
		res.dup_flag       = pub & nx.cflags[3];
		res.qos_level      = pub ? nx.cflags[2:1] : 2'd0;
		res.retain_flag    = pub & nx.cflags[0];
		res.ack_flags      = nx.ackf;
		res.return_code    = nx.retc;
		res.payload_length = nx.pcount;
	end

endmodule

/* sim/mqtt_packet_header_parser_core_test.sv */
`timescale 1ns / 1ps
// testbench for mqtt_packet_header_parser_core: directed and random mqtt byte streams,
// each result checked against an in-bench parse of the same stream
// depends on mqttp_pkg and the parser rtl

module mqtt_packet_header_parser_core_test;
	import mqttp_pkg::*;

	localparam int          HOLD_CYCLES  = 60;
	localparam int          STALL_LIMIT  = 2000;
	localparam int          SHOW_LIMIT   = 10;
	localparam logic [3:0]  T_CONNECT    = 4'd1;
	localparam logic [3:0]  T_PINGREQ    = 4'd12;
	localparam logic [3:0]  T_PINGRESP   = 4'd13;
	localparam logic [3:0]  T_DISCONNECT = 4'd14;
	localparam logic [3:0]  FLAGS_NONE   = 4'd0;

	typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} sink_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       rx_byte = 8'h00;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [3:0]       packet_type;
	logic [3:0]       byte_role;
	logic [7:0]       data_byte;
	logic             packet_end;
	logic [2:0]       error_code;
	logic [ID_W-1:0]  packet_id;
	logic             dup_flag;
	logic [1:0]       qos_level;
	logic             retain_flag;
	logic [7:0]       ack_flags;
	logic [7:0]       return_code;
	logic [LEN_W-1:0] payload_length;

	mqtt_packet_header_parser_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.packet_type    (packet_type),
		.byte_role      (byte_role),
		.data_byte      (data_byte),
		.packet_end     (packet_end),
		.error_code     (error_code),
		.packet_id      (packet_id),
		.dup_flag       (dup_flag),
		.qos_level      (qos_level),
		.retain_flag    (retain_flag),
		.ack_flags      (ack_flags),
		.return_code    (return_code),
		.payload_length (payload_length)
	);

	always #1 clk = ~clk;

	// parse state of the bench's own view of the stream
	phase_t           p_phase  = PH_WAIT;
	logic [3:0]       p_type   = 4'd0;
	logic [3:0]       p_flags  = 4'd0;
	logic [LEN_W-1:0] p_rem    = '0;
	logic [2:0]       p_lidx   = 3'd0;
	logic [ID_W-1:0]  p_tlen   = '0;
	logic [ID_W-1:0]  p_id     = '0;
	logic [LEN_W-1:0] p_pcount = '0;
	logic [7:0]       p_ackf   = 8'h00;
	logic [7:0]       p_retc   = 8'h00;

	res_t       byte_results_due[$];
	logic [7:0] pkt_bytes[$];

	sink_mode_t sink_mode = RDY_ALWAYS;
	bit         sender_gaps = 1'b0;
	int         burst_left = 0;
	int         hold_requests = 0;
	int         hold_served = 0;
	int         hold_left = 0;
	int         sink_tick = 0;
	int         quiet_cycles = 0;
	int         bytes_sent = 0;
	int         results_checked = 0;
	int         packet_ends = 0;
	int         mismatch_count = 0;
	int         err_tally[5] = '{0, 0, 0, 0, 0};
	res_t       got, want;

	function automatic logic [2:0] header_fault(input logic [3:0] t, input logic [3:0] f);
		if (t == T_PUBLISH) begin
			if (f[2:1] == 2'b11)
				return ERR_FLAGS;
		end else if (t == T_PUBREL || t == T_SUBSCR || t == T_UNSUB) begin
			if (f != FLAGS_REQ)
				return ERR_FLAGS;
		end else if (f != FLAGS_NONE) begin
			return ERR_FLAGS;
		end
		if (t == T_RSVD_LO || t == T_RSVD_HI)
			return ERR_TYPE;
		return ERR_NONE;
	endfunction

	function automatic int unsigned pub_id_len();
		return (p_flags[2:1] != 2'b00) ? 2 : 0;
	endfunction

	function automatic logic fixed_len_wrong();
		case (p_type)
			T_CONNACK, T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_UNSUBACK:
				return 32'(p_rem) != 2;
			T_SUBACK: return 32'(p_rem) != 3;
			T_PUBLISH: return 32'(p_rem) < 2 + pub_id_len();
			default: return 1'b0;
		endcase
	endfunction

	function automatic phase_t body_start();
		case (p_type)
			T_CONNACK: return PH_ACKF;
			T_PUBLISH: return PH_TLEN_HI;
			T_PUBACK, T_PUBREC, T_PUBREL, T_PUBCOMP, T_SUBACK, T_UNSUBACK: return PH_ID_HI;
			default: return PH_SKIP;
		endcase
	endfunction

	function automatic phase_t after_topic();
		return (pub_id_len() != 0) ? PH_ID_HI : PH_PAYLOAD;
	endfunction

	// advances the parse by one stream byte and gives the result it should produce
	function automatic res_t parse_stream_byte(input logic [7:0] b);
		res_t        r;
		logic [3:0]  role;
		logic [2:0]  err;
		logic        done;
		logic        hdr_ok;
		logic [31:0] acc;
		phase_t      nxt;
		role = ROLE_HDR;
		err = ERR_NONE;
		done = 1'b0;
		hdr_ok = 1'b1;
		case (p_phase)
			PH_LEN: begin
				role = ROLE_LEN;
				acc = 32'(p_rem) + (32'(b[6:0]) << (7 * p_lidx[1:0]));
				p_rem = acc[LEN_W-1:0];
				if (b[7]) begin
					if (p_lidx >= 3'd3) begin
						err = ERR_LONG;
						done = 1'b1;
					end else begin
						p_lidx = p_lidx + 3'd1;
					end
				end else if (fixed_len_wrong()) begin
					err = ERR_LEN;
					done = 1'b1;
				end else if (p_rem == '0) begin
					done = 1'b1;
				end else begin
					p_phase = body_start();
				end
			end
			PH_ID_HI, PH_ID_LO, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_PAYLOAD, PH_ACKF,
			PH_RETC, PH_SKIP: begin
				p_rem = p_rem - 1'b1;
				nxt = p_phase;
				case (p_phase)
					PH_ID_HI: begin
						role = ROLE_ID;
						p_id = {b, 8'h00};
						nxt = PH_ID_LO;
					end
					PH_ID_LO: begin
						role = ROLE_ID;
						p_id = p_id | {8'h00, b};
						nxt = (p_type == T_SUBACK) ? PH_RETC : PH_PAYLOAD;
					end
					PH_TLEN_HI: begin
						role = ROLE_TLEN;
						p_tlen = {b, 8'h00};
						nxt = PH_TLEN_LO;
					end
					PH_TLEN_LO: begin
						role = ROLE_TLEN;
						p_tlen = p_tlen | {8'h00, b};
						if (32'(p_tlen) + pub_id_len() > 32'(p_rem)) begin
							err = ERR_LEN;
						end else begin
							p_pcount = LEN_W'(32'(p_rem) - 32'(p_tlen) - pub_id_len());
							nxt = (p_tlen != '0) ? PH_TOPIC : after_topic();
						end
					end
					PH_TOPIC: begin
						role = ROLE_TOPIC;
						if (32'(p_rem) == 32'(p_pcount) + pub_id_len())
							nxt = after_topic();
					end
					PH_PAYLOAD: role = ROLE_PAYLD;
					PH_ACKF: begin
						role = ROLE_ACKF;
						p_ackf = b;
						nxt = PH_RETC;
					end
					PH_RETC: begin
						role = ROLE_RETC;
						p_retc = b;
					end
					default: role = ROLE_SKIP;
				endcase
				if (err != ERR_NONE || p_rem == '0)
					done = 1'b1;
				else
					p_phase = nxt;
			end
			default: begin
				p_type = b[7:4];
				p_flags = b[3:0];
				p_rem = '0;
				p_lidx = 3'd0;
				p_tlen = '0;
				p_id = '0;
				p_pcount = '0;
				p_ackf = 8'h00;
				p_retc = 8'h00;
				err = header_fault(p_type, p_flags);
				if (err != ERR_NONE) begin
					done = 1'b1;
					hdr_ok = 1'b0;
				end else begin
					p_phase = PH_LEN;
				end
			end
		endcase
		if (done)
			p_phase = PH_WAIT;
		hdr_ok = hdr_ok && (p_type == T_PUBLISH);
		r.packet_type    = p_type;
		r.byte_role      = role;
		r.data_byte      = b;
		r.packet_end     = done;
		r.error_code     = err;
		r.packet_id      = p_id;
		r.dup_flag       = hdr_ok ? p_flags[3] : 1'b0;
		r.qos_level      = hdr_ok ? p_flags[2:1] : 2'b00;
		r.retain_flag    = hdr_ok ? p_flags[0] : 1'b0;
		r.ack_flags      = p_ackf;
		r.return_code    = p_retc;
		r.payload_length = p_pcount;
		return r;
	endfunction

	function automatic string show_result(input res_t r);
		return $sformatf({"type=%0d role=%0d byte=%02h end=%0b err=%0d id=%04h ",
			"dup=%0b qos=%0d ret=%0b ackf=%02h rc=%02h plen=%0d"},
			r.packet_type, r.byte_role, r.data_byte, r.packet_end, r.error_code,
			r.packet_id, r.dup_flag, r.qos_level, r.retain_flag, r.ack_flags,
			r.return_code, r.payload_length);
	endfunction

	// sender: one byte per transfer, bursts with random gaps when enabled
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (sender_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left = burst_left - 1;
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		byte_results_due.push_back(parse_stream_byte(b));
		bytes_sent = bytes_sent + 1;
	endtask

	task automatic sender_idle();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_pkt();
		foreach (pkt_bytes[i])
			send_byte(pkt_bytes[i]);
		pkt_bytes.delete();
	endtask

	// finish whatever packet the stream has left open
	task automatic resync();
		while (p_phase != PH_WAIT)
			send_byte(p_phase == PH_LEN ? 8'($urandom_range(0, 12)) : 8'($urandom));
	endtask

	task automatic push_random(input int unsigned n);
		repeat (n) pkt_bytes.push_back(8'($urandom));
	endtask

	// remaining length, low group first; padding adds redundant zero groups
	task automatic push_length(input int unsigned n, input bit pad);
		int unsigned v;
		int unsigned used;
		v = n;
		used = 0;
		do begin
			pkt_bytes.push_back({(v >> 7) != 0, 7'(v)});
			v = v >> 7;
			used++;
		end while (v != 0);
		if (pad && used < 4) begin
			pkt_bytes[pkt_bytes.size() - 1] = pkt_bytes[pkt_bytes.size() - 1] | 8'h80;
			repeat ($urandom_range(0, 3 - used)) pkt_bytes.push_back(8'h80);
			pkt_bytes.push_back(8'h00);
		end
	endtask

	function automatic logic [7:0] ack_header(input int unsigned k);
		case (k)
			0: return {T_PUBACK, FLAGS_NONE};
			1: return {T_PUBREC, FLAGS_NONE};
			2: return {T_PUBREL, FLAGS_REQ};
			3: return {T_PUBCOMP, FLAGS_NONE};
			4: return {T_UNSUBACK, FLAGS_NONE};
			default: return {T_SUBACK, FLAGS_NONE};
		endcase
	endfunction

	function automatic logic [7:0] skip_header(input int unsigned k);
		case (k)
			0: return {T_CONNECT, FLAGS_NONE};
			1: return {T_SUBSCR, FLAGS_REQ};
			2: return {T_UNSUB, FLAGS_REQ};
			3: return {T_PINGREQ, FLAGS_NONE};
			4: return {T_PINGRESP, FLAGS_NONE};
			default: return {T_DISCONNECT, FLAGS_NONE};
		endcase
	endfunction

	task automatic random_packet();
		int unsigned sel, tl, pl, idn, rem, k, need;
		logic [3:0]  fl;
		logic [7:0]  h;
		bit          pad;
		sel = $urandom_range(0, 99);
		pad = ($urandom_range(0, 7) == 0);
		fl = {1'($urandom), 2'($urandom_range(0, 2)), 1'($urandom)};
		idn = (fl[2:1] != 2'b00) ? 2 : 0;
		if (sel < 25 || sel >= 93) begin
			tl = $urandom_range(0, 6);
			pl = (sel >= 93) ? $urandom_range(100, 160) : $urandom_range(0, 8);
			pkt_bytes.push_back({T_PUBLISH, fl});
			push_length(2 + tl + idn + pl, pad);
			pkt_bytes.push_back(8'(tl >> 8));
			pkt_bytes.push_back(8'(tl));
			push_random(tl + idn + pl);
		end else if (sel < 35) begin
			pkt_bytes.push_back({T_CONNACK, FLAGS_NONE});
			push_length(2, pad);
			push_random(2);
		end else if (sel < 55) begin
			pkt_bytes.push_back(ack_header($urandom_range(0, 4)));
			push_length(2, pad);
			push_random(2);
		end else if (sel < 63) begin
			pkt_bytes.push_back({T_SUBACK, FLAGS_NONE});
			push_length(3, pad);
			push_random(3);
		end else if (sel < 73) begin
			rem = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 200) : $urandom_range(0, 10);
			pkt_bytes.push_back(skip_header($urandom_range(0, 5)));
			push_length(rem, pad);
			push_random(rem);
		end else if (sel < 85) begin
			case ($urandom_range(0, 4))
				0: begin
					do h = 8'($urandom); while (header_fault(h[7:4], h[3:0]) == ERR_NONE);
					pkt_bytes.push_back(h);
				end
				1: begin
					k = $urandom_range(0, 5);
					need = (k == 5) ? 3 : 2;
					do rem = $urandom_range(0, 6); while (rem == need);
					pkt_bytes.push_back(ack_header(k));
					push_length(rem, pad);
				end
				2: begin
					pkt_bytes.push_back({T_PUBLISH, fl});
					push_length($urandom_range(0, 1 + idn), pad);
				end
				3: begin
					k = $urandom_range(0, 5);
					tl = $urandom_range(k + 1, 65535);
					pkt_bytes.push_back({T_PUBLISH, fl});
					push_length(2 + idn + k, pad);
					pkt_bytes.push_back(8'(tl >> 8));
					pkt_bytes.push_back(8'(tl));
				end
				default: begin
					pkt_bytes.push_back({T_PUBLISH, fl});
					repeat (4) pkt_bytes.push_back(8'h80 | 8'($urandom));
				end
			endcase
		end else begin
			repeat ($urandom_range(1, 3))
				send_byte(p_phase == PH_LEN ? 8'($urandom_range(0, 12)) : 8'($urandom));
		end
		send_pkt();
		resync();
	endtask

	task automatic pause_until_empty();
		sender_idle();
		while (byte_results_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_header_errors();
		sender_gaps = 1'b0;
		sink_mode = RDY_ALWAYS;
		// reserved types, flags on a reserved type, publish with qos 3
		pkt_bytes = '{8'h00, 8'hFF, 8'hF0, 8'h37};
		send_pkt();
	endtask

	task automatic test_directed_packets();
		sink_mode = RDY_PATTERN;
		// connack, ack with wrong length, empty body with padded length, overlong length,
		// qos 2 publish with topic, id and payload, publish whose topic overruns
		pkt_bytes = '{8'h20, 8'h02, 8'h80, 8'h7F, 8'h40, 8'h03, 8'hC0, 8'h80, 8'h00,
			8'h3B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h3D, 8'h06, 8'h00, 8'h01, 8'h41, 8'h12, 8'h34, 8'h5A,
			8'h30, 8'h03, 8'h00, 8'h02};
		send_pkt();
		pause_until_empty();
	endtask

	task automatic test_random_stream(input int budget, input sink_mode_t mode);
		int target;
		target = bytes_sent + budget;
		sender_gaps = 1'b1;
		sink_mode = mode;
		while (bytes_sent < target)
			random_packet();
	endtask

	task automatic test_full_rate(input int budget);
		int target;
		target = bytes_sent + budget;
		sender_gaps = 1'b0;
		sink_mode = RDY_ALWAYS;
		while (bytes_sent < target)
			random_packet();
	endtask

	task automatic test_output_holdoff();
		int target;
		sender_gaps = 1'b0;
		sink_mode = RDY_RANDOM;
		repeat (2) begin
			hold_requests = hold_requests + 1;
			target = bytes_sent + 100;
			while (bytes_sent < target)
				random_packet();
		end
	endtask

	task automatic test_drain_pause();
		sender_gaps = 1'b1;
		sink_mode = RDY_PATTERN;
		repeat (4) begin
			repeat (3) random_packet();
			pause_until_empty();
		end
	endtask

	// receiver: ready pattern per mode, with long hold-offs on request
	always @(negedge clk) begin
		sink_tick = sink_tick + 1;
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready = 1'b0;
		end else begin
			case (sink_mode)
				RDY_ALWAYS: out_ready = 1'b1;
				RDY_RANDOM: out_ready = ($urandom_range(0, 9) < 7);
				default: out_ready = ((sink_tick % 13) < 8);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = {packet_type, byte_role, data_byte, packet_end, error_code, packet_id,
				dup_flag, qos_level, retain_flag, ack_flags, return_code, payload_length};
			if (byte_results_due.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= SHOW_LIMIT)
					$display("unexpected result: %s", show_result(got));
			end else begin
				want = byte_results_due.pop_front();
				results_checked = results_checked + 1;
				if (want.packet_end)
					packet_ends = packet_ends + 1;
				err_tally[want.error_code] = err_tally[want.error_code] + 1;
				if (got.packet_type !== want.packet_type || got.byte_role !== want.byte_role ||
						got.data_byte !== want.data_byte || got.packet_end !== want.packet_end ||
						got.error_code !== want.error_code || got.packet_id !== want.packet_id ||
						got.dup_flag !== want.dup_flag || got.qos_level !== want.qos_level ||
						got.retain_flag !== want.retain_flag || got.ack_flags !== want.ack_flags ||
						got.return_code !== want.return_code ||
						got.payload_length !== want.payload_length) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= SHOW_LIMIT) begin
						$display("mismatch at result %0d", results_checked);
						$display("  expected %s", show_result(want));
						$display("  actual   %s", show_result(got));
					end
				end
			end
		end
	end

	// no transfer on either side for too long means the block has hung
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("mqtt_packet_header_parser_core verification failed");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_header_errors();
		test_directed_packets();
		test_random_stream(350, RDY_RANDOM);
		test_random_stream(300, RDY_PATTERN);
		test_full_rate(250);
		test_output_holdoff();
		test_drain_pause();
		pause_until_empty();
		repeat (10) @(posedge clk);
		$display("stream of %0d bytes, %0d results checked, %0d packets closed",
			bytes_sent, results_checked, packet_ends);
		$display("errors seen: flags %0d, type %0d, length %0d, overlong length %0d",
			err_tally[ERR_FLAGS], err_tally[ERR_TYPE], err_tally[ERR_LEN], err_tally[ERR_LONG]);
		if (mismatch_count == 0)
			$display("mqtt_packet_header_parser_core verification clean");
		else
			$display("mqtt_packet_header_parser_core verification failed");
		$finish;
	end

endmodule

/* sim.f */
hdl/mqttp_pkg.sv
hdl/mqttp_step.sv
hdl/mqtt_packet_header_parser_core.sv
sim/mqtt_packet_header_parser_core_test.sv
